@@ rtl/core/bdot_pkg.sv @@
// Shared types, constants and codes for the B-dot coil controller.
`default_nettype none
package bdot_pkg;

   localparam int unsigned VecW     = 24;
   localparam int unsigned TimeW    = 48;
   localparam int unsigned CoilW    = 16;
   localparam int unsigned GainW    = 32;
   localparam int unsigned LimW     = 15;
   localparam int unsigned StaleW   = 32;
   localparam int unsigned MinW     = 23;
   // Product of gain and field delta magnitude.
   localparam int unsigned ProdW    = GainW + VecW + 1;
   // Divisor is the interval shifted up by 16.
   localparam int unsigned DenW     = TimeW + 16;
   localparam int unsigned AddrW    = 4;

   localparam logic [GainW-1:0]  GainReset  = 32'd65536;
   localparam logic [LimW-1:0]   LimitReset = 15'd32767;
   localparam logic [StaleW-1:0] StaleReset = 32'd1000000;
   localparam logic [MinW-1:0]   MinReset   = 23'd100;

   // Register byte addresses.
   localparam logic [AddrW-1:0] AddrGain  = 4'h0;
   localparam logic [AddrW-1:0] AddrLimit = 4'h4;
   localparam logic [AddrW-1:0] AddrStale = 4'h8;
   localparam logic [AddrW-1:0] AddrMin   = 4'hC;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_DIRECT = 2'd2,
      OP_ENABLE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_STORED   = 4'd0,
      ST_OFF      = 4'd1,
      ST_NOFIELD  = 4'd2,
      ST_STALE    = 4'd3,
      ST_PRIMED   = 4'd4,
      ST_BADDT    = 4'd5,
      ST_WEAK     = 4'd6,
      ST_BDOT     = 4'd7,
      ST_DIRECT   = 4'd8,
      ST_DISABLED = 4'd9,
      ST_ENABLED  = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_MAG,
      S_START,
      S_DIV,
      S_CLIP,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [VecW-1:0]  vec_x;
      logic signed [VecW-1:0]  vec_y;
      logic signed [VecW-1:0]  vec_z;
      logic [TimeW-1:0]        time_us;
      logic                    enable;
   } req_type;

   typedef struct packed {
      logic                    coil_valid;
      logic signed [CoilW-1:0] coil_x;
      logic signed [CoilW-1:0] coil_y;
      logic signed [CoilW-1:0] coil_z;
      logic [2:0]              sat_mask;
      logic [3:0]              status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the incoming item
      logic decide;    // evaluate op and tick checks
      logic mag_step;  // accumulate one axis of squared magnitude
      logic div_start; // start division for current axis
      logic clip_axis; // clip quotient of current axis
      logic finish;    // update state and form result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_law;   // tick reaches the dipole law
      logic mag_done;
      logic div_done;
      logic last_axis;
      logic weak_field; // field magnitude below the threshold
      logic is_direct;  // item is a direct dipole command
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/core/bdot_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module bdot_divider
   import bdot_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ProdW-1:0] dividend,
   input  wire logic [DenW-1:0]  divisor,
   output logic                  done,
   output logic [ProdW-1:0]      quotient
);

   localparam int unsigned CntW = $clog2(ProdW + 1);

   logic [ProdW-1:0] quo_ff, quo_in;
   logic [DenW:0]    rem_ff, rem_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DenW:0]    trial;

   // One shift-subtract step per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenW-1:0], quo_ff[ProdW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntW'(ProdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[ProdW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[ProdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/bdot_datapath.sv @@
// Datapath: sample store, tick checks, magnitude, law and saturation.
`default_nettype none
module bdot_datapath
   import bdot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_type           req,
   input  wire cmd_type           cmd,
   input  wire logic [GainW-1:0]  gain_q16,
   input  wire logic [LimW-1:0]   coil_limit,
   input  wire logic [StaleW-1:0] stale_limit_us,
   input  wire logic [MinW-1:0]   min_field_nt,
   output sts_type                sts,
   output rsp_type                result
);

   // Stored state.
   logic signed [VecW-1:0] now_ff [3];
   logic signed [VecW-1:0] prev_ff [3];
   logic [TimeW-1:0]       now_t_ff, prev_t_ff;
   logic                   now_v_ff, prev_v_ff, on_ff;

   // Working registers.
   req_type                item_ff;
   logic [3:0]             status_ff;
   logic                   valid_ff;
   logic                   take_ff;
   logic                   law_ff;
   logic [1:0]             axis_ff;
   logic [48:0]            mag2_ff;
   logic [DenW-1:0]        den_ff;
   logic signed [CoilW-1:0] coil_ff [3];
   logic [2:0]             sat_ff;
   logic                   neg_ff;
   logic [ProdW-1:0]       prod_ff;
   logic                   prod_go_ff;
   rsp_type                result_ff;

   logic [TimeW-1:0]       age;
   logic                   div_done;
   logic [ProdW-1:0]       quo;
   logic signed [VecW:0]   db;
   logic [VecW:0]          adb;
   logic [VecW-1:0]        afield;
   logic signed [VecW-1:0] vsel;
   logic                   vneg;
   logic [VecW:0]          vmag;

   // Age of the stored sample; an earlier current time counts as zero.
   assign age = (item_ff.time_us >= now_t_ff) ? item_ff.time_us - now_t_ff : '0;

   // Delta of the axis under work.
   assign db  = {now_ff[axis_ff][VecW-1], now_ff[axis_ff]}
              - {prev_ff[axis_ff][VecW-1], prev_ff[axis_ff]};
   assign adb = db[VecW] ? (VecW+1)'(0) - db : db;
   assign afield = now_ff[axis_ff][VecW-1] ? VecW'(0) - now_ff[axis_ff] : now_ff[axis_ff];

   // Direct command axis select.
   always_comb begin
      case (axis_ff)
         2'd0:    vsel = item_ff.vec_x;
         2'd1:    vsel = item_ff.vec_y;
         default: vsel = item_ff.vec_z;
      endcase
      vneg = vsel[VecW-1];
      vmag = vneg ? (VecW+1)'(0) - {vsel[VecW-1], vsel} : {1'b0, vsel};
   end

   bdot_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (prod_go_ff),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // Status back to the controller.
   always_comb begin
      sts.need_law   = law_ff;
      sts.mag_done   = (axis_ff == 2'd2);
      sts.div_done   = div_done;
      sts.last_axis  = (axis_ff == 2'd2);
      sts.weak_field = (status_ff == ST_WEAK);
      sts.is_direct  = (item_ff.op == OP_DIRECT);
   end

   assign result = result_ff;

   // Control state of the stored samples.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_v_ff  <= 1'b0;
         prev_v_ff <= 1'b0;
         on_ff     <= 1'b0;
         now_t_ff  <= '0;
         prev_t_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            now_ff[i]  <= '0;
            prev_ff[i] <= '0;
         end
         prod_go_ff <= 1'b0;
      end else begin
         prod_go_ff <= cmd.div_start;
         if (cmd.finish) begin
            case (op_type'(item_ff.op))
               OP_SAMPLE: begin
                  now_ff[0] <= item_ff.vec_x;
                  now_ff[1] <= item_ff.vec_y;
                  now_ff[2] <= item_ff.vec_z;
                  now_t_ff  <= item_ff.time_us;
                  now_v_ff  <= 1'b1;
               end
               OP_ENABLE: begin
                  on_ff <= item_ff.enable;
                  if (item_ff.enable) begin
                     now_v_ff  <= 1'b0;
                     prev_v_ff <= 1'b0;
                  end
               end
               default: begin
                  if (take_ff) begin
                     for (int i = 0; i < 3; i++) prev_ff[i] <= now_ff[i];
                     prev_t_ff <= now_t_ff;
                     prev_v_ff <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Item working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req;
         axis_ff <= '0;
         mag2_ff <= '0;
         sat_ff  <= '0;
         law_ff  <= 1'b0;
         take_ff <= 1'b0;
         valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) coil_ff[i] <= '0;
      end
      if (cmd.decide) begin
         law_ff <= 1'b0;
         case (op_type'(item_ff.op))
            OP_SAMPLE: status_ff <= ST_STORED;
            OP_DIRECT: begin
               status_ff <= ST_DIRECT;
               valid_ff  <= 1'b1;
            end
            OP_ENABLE: begin
               status_ff <= item_ff.enable ? ST_ENABLED : ST_DISABLED;
               valid_ff  <= !item_ff.enable;
            end
            default: begin
               if (!on_ff) status_ff <= ST_OFF;
               else if (!now_v_ff) status_ff <= ST_NOFIELD;
               else if (age >= TimeW'(stale_limit_us)) status_ff <= ST_STALE;
               else if (!prev_v_ff) begin
                  status_ff <= ST_PRIMED;
                  take_ff   <= 1'b1;
               end else if (now_t_ff <= prev_t_ff) begin
                  status_ff <= ST_BADDT;
                  take_ff   <= 1'b1;
               end else begin
                  law_ff   <= 1'b1;
                  take_ff  <= 1'b1;
                  valid_ff <= 1'b1;
                  den_ff   <= {now_t_ff - prev_t_ff, 16'd0};
               end
            end
         endcase
      end
      // Squared magnitude, one axis a cycle.
      if (cmd.mag_step) begin
         mag2_ff <= mag2_ff + 49'(afield * afield);
         axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
         if (axis_ff == 2'd2) begin
            if ((mag2_ff + 49'(afield * afield)) < 49'(min_field_nt * min_field_nt))
               status_ff <= ST_WEAK;
            else
               status_ff <= ST_BDOT;
         end
      end
      // Product for the law; dipole opposes the change.
      if (cmd.div_start) begin
         prod_ff <= ProdW'(gain_q16 * adb);
         neg_ff  <= (db > 0);
      end
      // Clip one axis: law quotient or direct command.
      if (cmd.clip_axis) begin
         logic [ProdW-1:0] m;
         logic             n;
         m = law_ff ? quo : ProdW'(vmag);
         n = law_ff ? neg_ff : vneg;
         if (m > ProdW'(coil_limit)) begin
            m = ProdW'(coil_limit);
            sat_ff[axis_ff] <= 1'b1;
         end
         coil_ff[axis_ff] <= n ? CoilW'(0) - CoilW'(m) : CoilW'(m);
         axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
      end
      if (cmd.finish) begin
         result_ff.coil_valid <= valid_ff;
         result_ff.coil_x     <= coil_ff[0];
         result_ff.coil_y     <= coil_ff[1];
         result_ff.coil_z     <= coil_ff[2];
         result_ff.sat_mask   <= sat_ff;
         result_ff.status     <= status_ff;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/bdot_control.sv @@
// Controller state machine sequencing the datapath for each item.
`default_nettype none
module bdot_control
   import bdot_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_v_ff, out_v_in;
   logic      clip_law_ff, clip_law_in;

   // Next state.
   always_comb begin
      state_in    = state_ff;
      clip_law_in = clip_law_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECIDE;
         S_DECIDE: begin
            if (sts.is_direct) begin
               state_in    = S_CLIP;
               clip_law_in = 1'b0;
            end else state_in = S_MAG;
         end
         S_MAG: begin
            if (!sts.need_law) state_in = S_OUT;
            else if (sts.mag_done) state_in = S_START;
         end
         S_START: begin
            if (sts.weak_field) state_in = S_OUT;
            else state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in    = S_CLIP;
               clip_law_in = 1'b1;
            end
         end
         S_CLIP: begin
            if (sts.last_axis) state_in = S_OUT;
            else if (clip_law_ff) state_in = S_START;
         end
         S_OUT:    if (!out_v_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd           = '0;
      req_ready     = (state_ff == S_IDLE);
      cmd.load      = req_valid && (state_ff == S_IDLE);
      cmd.decide    = (state_ff == S_DECIDE);
      cmd.mag_step  = (state_ff == S_MAG) && sts.need_law;
      cmd.div_start = (state_ff == S_START) && !sts.weak_field;
      cmd.clip_axis = (state_ff == S_CLIP);
      cmd.finish    = (state_ff == S_OUT) && (!out_v_ff || rsp_ready);
      out_v_in      = cmd.finish ? 1'b1 : (out_v_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_v_ff    <= 1'b0;
         clip_law_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_v_ff    <= out_v_in;
         clip_law_ff <= clip_law_in;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule
`default_nettype wire

@@ rtl/core/bdot_detumble_coil_controller.sv @@
// Top level of the B-dot detumble coil controller.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_ready     | req_type
//  rsp     | out       | rsp_valid / rsp_ready     | rsp_type
//  csr     | in        | APB-style psel / penable  | 32-bit registers
//
// Samples, enables and ticks that stop before the law are decided and output; direct
// commands also clip each axis, and weak-field ticks also sum the squared magnitude.
// A tick through the dipole law runs, per axis, a start state, the shared
// one-bit-per-cycle divider (57 quotient bits) and a clip state.
// One item is worked at a time; the next item is taken while a result waits.
// Reset is synchronous and clears all sample flags and disables the law.
`default_nettype none
module bdot_detumble_coil_controller
   import bdot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [AddrW-1:0]  paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [GainW-1:0]  gain_ff;
   logic [LimW-1:0]   limit_ff;
   logic [StaleW-1:0] stale_ff;
   logic [MinW-1:0]   min_ff;
   cmd_type           cmd;
   sts_type           sts;
   rsp_type           dp_result;
   logic              wr;

   // Configuration registers.
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GainReset;
         limit_ff <= LimitReset;
         stale_ff <= StaleReset;
         min_ff   <= MinReset;
      end else if (wr) begin
         case (paddr)
            AddrGain:  gain_ff  <= pwdata;
            AddrLimit: limit_ff <= pwdata[LimW-1:0];
            AddrStale: stale_ff <= pwdata;
            AddrMin:   min_ff   <= pwdata[MinW-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         AddrGain:  prdata = gain_ff;
         AddrLimit: prdata = 32'(limit_ff);
         AddrStale: prdata = stale_ff;
         AddrMin:   prdata = 32'(min_ff);
         default:   prdata = '0;
      endcase
   end

   bdot_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdot_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req            (req_data),
      .cmd            (cmd),
      .gain_q16       (gain_ff),
      .coil_limit     (limit_ff),
      .stale_limit_us (stale_ff),
      .min_field_nt   (min_ff),
      .sts            (sts),
      .result         (dp_result)
   );

   assign rsp_data = dp_result;

endmodule
`default_nettype wire

@@ rtl/core/bdot_checker.sv @@
// Port-level checker for the B-dot coil controller, bound to the top level.
`default_nettype none
module bdot_checker
   import bdot_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A waiting result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // Accepting an item never happens in the cycle right after another.
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // Coil values stay within the 15-bit symmetric range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.coil_x != 16'sh8000) && (rsp_data.coil_y != 16'sh8000)
                    && (rsp_data.coil_z != 16'sh8000))
      else $error("coil out of range");

   // Only commands that clip report saturation.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.sat_mask != 3'd0) |->
         (rsp_data.status == ST_BDOT) || (rsp_data.status == ST_DIRECT))
      else $error("sat_mask without command");

endmodule

bind bdot_detumble_coil_controller bdot_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

@@ tb/bdot_detumble_coil_controller_test.sv @@
// Self-checking testbench for the B-dot detumble coil controller.
`timescale 1ns / 100ps
`default_nettype none
module bdot_detumble_coil_controller_test;
   import bdot_pkg::*;

   localparam int unsigned StallLimit = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [AddrW-1:0]      paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Predictor copy of the registers and the sample store.
   longint unsigned       gain_reg, limit_reg, stale_reg, min_reg;
   longint                now_field [3];
   longint                prev_field [3];
   longint unsigned       now_time, prev_time;
   bit                    now_ok, prev_ok, law_on;

   rsp_type               coil_queue [$];
   int                    error_count = 0;
   int                    result_count = 0;
   int                    law_count = 0;
   int                    item_count = 0;
   int                    idle_cycles = 0;
   int                    stall_left = 0;
   bit                    idling = 1'b1;
   longint unsigned       clock_us = 64'd1000;

   bdot_detumble_coil_controller uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // Clip one axis magnitude to the coil limit and apply its sign.
   function automatic logic [CoilW-1:0] clip_coil(bit neg, longint unsigned mag, int axis,
                                                  inout logic [2:0] sat);
      longint unsigned m;
      m = mag;
      if (m > limit_reg) begin
         m = limit_reg;
         sat[axis] = 1'b1;
      end
      return neg ? CoilW'(-longint'(m)) : CoilW'(m);
   endfunction

   // Work out the coil command one item causes and update the predicted state.
   function automatic rsp_type predict_coil(req_type r);
      rsp_type         o;
      longint          v [3];
      longint          db;
      longint unsigned t, age, dt, mag2, thr2, a, den, mag;
      logic [CoilW-1:0] c [3];
      logic [2:0]      sat;
      o = '0;
      sat = '0;
      c[0] = '0; c[1] = '0; c[2] = '0;
      t = r.time_us;
      v[0] = $signed(r.vec_x);
      v[1] = $signed(r.vec_y);
      v[2] = $signed(r.vec_z);
      case (op_type'(r.op))
         OP_SAMPLE: begin
            now_field = v;
            now_time = t;
            now_ok = 1'b1;
            o.status = ST_STORED;
         end
         OP_TICK: begin
            age = (t >= now_time) ? t - now_time : 0;
            if (!law_on) begin
               o.status = ST_OFF;
            end else if (!now_ok) begin
               o.status = ST_NOFIELD;
            end else if (age >= stale_reg) begin
               o.status = ST_STALE;
            end else if (!prev_ok || now_time <= prev_time) begin
               o.status = prev_ok ? ST_BADDT : ST_PRIMED;
               prev_field = now_field;
               prev_time = now_time;
               prev_ok = 1'b1;
            end else begin
               dt = now_time - prev_time;
               mag2 = 0;
               for (int i = 0; i < 3; i++) begin
                  a = (now_field[i] < 0) ? -now_field[i] : now_field[i];
                  mag2 += a * a;
               end
               thr2 = min_reg * min_reg;
               o.coil_valid = 1'b1;
               if (mag2 < thr2) begin
                  o.status = ST_WEAK;
               end else begin
                  den = dt << 16;
                  for (int i = 0; i < 3; i++) begin
                     db = now_field[i] - prev_field[i];
                     a = (db < 0) ? -db : db;
                     mag = (gain_reg * a) / den;
                     // The dipole opposes the change in field.
                     c[i] = clip_coil(db > 0, mag, i, sat);
                  end
                  o.status = ST_BDOT;
               end
               prev_field = now_field;
               prev_time = now_time;
               prev_ok = 1'b1;
            end
         end
         OP_DIRECT: begin
            for (int i = 0; i < 3; i++)
               c[i] = clip_coil(v[i] < 0, (v[i] < 0) ? -v[i] : v[i], i, sat);
            o.coil_valid = 1'b1;
            o.status = ST_DIRECT;
         end
         default: begin
            if (r.enable) begin
               law_on = 1'b1;
               now_ok = 1'b0;
               prev_ok = 1'b0;
               o.status = ST_ENABLED;
            end else begin
               law_on = 1'b0;
               o.coil_valid = 1'b1;
               o.status = ST_DISABLED;
            end
         end
      endcase
      o.coil_x = c[0];
      o.coil_y = c[1];
      o.coil_z = c[2];
      o.sat_mask = sat;
      return o;
   endfunction

   // Report one mismatch and count it.
   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Result checker: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (coil_queue.size() == 0) begin
            report_mismatch("result with nothing pending, status", rsp_data.status, -1);
         end else begin
            want = coil_queue.pop_front();
            if (rsp_data.coil_valid !== want.coil_valid)
               report_mismatch("coil_valid", rsp_data.coil_valid, want.coil_valid);
            if (rsp_data.coil_x !== want.coil_x)
               report_mismatch("coil_x", $signed(rsp_data.coil_x), $signed(want.coil_x));
            if (rsp_data.coil_y !== want.coil_y)
               report_mismatch("coil_y", $signed(rsp_data.coil_y), $signed(want.coil_y));
            if (rsp_data.coil_z !== want.coil_z)
               report_mismatch("coil_z", $signed(rsp_data.coil_z), $signed(want.coil_z));
            if (rsp_data.sat_mask !== want.sat_mask)
               report_mismatch("sat_mask", rsp_data.sat_mask, want.sat_mask);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (want.status == ST_BDOT)
               law_count++;
         end
      end
   end

   // Result side backpressure in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Timeout: no item moved for %0d cycles.", StallLimit);
         $display("bdot_detumble_coil_controller: mismatch");
         $finish;
      end
   end

   // Send one item, wait for it to be accepted and predict its result.
   task automatic send_item(req_type r);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      coil_queue.push_back(predict_coil(r));
      item_count++;
   endtask

   task automatic send_op(op_type op, longint x, longint y, longint z,
                          longint unsigned t, bit en);
      req_type r;
      r.op = op;
      r.vec_x = VecW'(x);
      r.vec_y = VecW'(y);
      r.vec_z = VecW'(z);
      r.time_us = TimeW'(t);
      r.enable = en;
      send_item(r);
   endtask

   // Stop sending and wait until every predicted result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (coil_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register write: setup cycle, access cycle, then an idle cycle.
   task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (addr)
         AddrGain:  gain_reg = value;
         AddrLimit: limit_reg = value[LimW-1:0];
         AddrStale: stale_reg = value;
         default:   min_reg = value[MinW-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] gain, logic [31:0] lim, logic [31:0] stale,
                             logic [31:0] min_nt);
      write_reg(AddrGain, gain);
      write_reg(AddrLimit, lim);
      write_reg(AddrStale, stale);
      write_reg(AddrMin, min_nt);
   endtask

   // Each special case of the law and command paths, in order.
   task automatic test_directed();
      send_op(OP_TICK, 0, 0, 0, 100, 1'b0);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b1);
      send_op(OP_TICK, 0, 0, 0, 200, 1'b0);
      send_op(OP_SAMPLE, 20000, -30000, 5000, 1000, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 1100, 1'b0);
      send_op(OP_SAMPLE, 21000, -30000, 5000, 1000, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 1100, 1'b0);
      send_op(OP_SAMPLE, 50, -40, 30, 2000, 1'b1);
      send_op(OP_TICK, 0, 0, 0, 2000, 1'b0);
      send_op(OP_SAMPLE, 8388607, -8388608, 0, 2001, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 1500, 1'b0);
      send_op(OP_SAMPLE, -8388608, 8388607, 1, 2002, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 1002001, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 2003, 1'b0);
      send_op(OP_DIRECT, 8388607, -8388608, 0, 0, 1'b0);
      send_op(OP_DIRECT, -32767, 32767, -1, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b1);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b1);
      send_op(OP_SAMPLE, 3000, 3000, 3000, 48'hFFFF_FFFF_FFF0, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_op(OP_SAMPLE, -3000, 100, 9000, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_op(OP_TICK, -1, -1, -1, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Extreme register settings with short sample and tick sequences.
   task automatic test_extremes();
      set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd8388607);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b1);
      send_op(OP_SAMPLE, 1000, 2000, 3000, 500, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 500, 1'b0);
      send_op(OP_DIRECT, 5, -5, 0, 0, 1'b0);
      drain();
      set_config(32'hFFFF_FFFF, 32'd32767, 32'hFFFF_FFFF, 32'd0);
      send_op(OP_ENABLE, 0, 0, 0, 0, 1'b1);
      send_op(OP_SAMPLE, 1, 0, 0, 10, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 10, 1'b0);
      send_op(OP_SAMPLE, 8388607, -8388608, 2, 11, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 48'hFFFF_FFFF, 1'b0);
      drain();
      set_config(32'd0, 32'd1, 32'd1, 32'd8388607);
      send_op(OP_SAMPLE, 8388607, 8388607, 8388607, 20, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 20, 1'b0);
      send_op(OP_SAMPLE, -8388608, -8388608, -8388608, 30, 1'b0);
      send_op(OP_TICK, 0, 0, 0, 30, 1'b0);
      drain();
   endtask

   function automatic longint rand_vec(bit narrow);
      if (narrow)
         return longint'($urandom_range(0, 1200)) - 600;
      return $signed(VecW'($urandom));
   endfunction

   // Mostly sample and tick sequences with advancing time, plus noise.
   task automatic test_random(int count, bit hold_off);
      int              pick;
      longint unsigned t;
      bit              narrow;
      for (int i = 0; i < count; i++) begin
         if (hold_off && i == count / 2)
            drain();
         pick = $urandom_range(0, 99);
         narrow = ($urandom_range(0, 2) == 0);
         if (pick < 5) begin
            send_op(OP_ENABLE, rand_vec(0), rand_vec(0), rand_vec(0),
                    {$urandom, $urandom}, $urandom_range(0, 9) != 0);
         end else if (pick < 12) begin
            send_op(OP_DIRECT, rand_vec(narrow), rand_vec(0), rand_vec(narrow),
                    {$urandom, $urandom}, $urandom_range(0, 1));
         end else if (pick < 18) begin
            // Noise: arbitrary times, which make stale, backward or wrapped cases.
            send_op(($urandom_range(0, 1) != 0) ? OP_SAMPLE : OP_TICK,
                    rand_vec(0), rand_vec(0), rand_vec(0), {$urandom, $urandom},
                    $urandom_range(0, 1));
         end else if (pick < 58) begin
            clock_us += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
            send_op(OP_SAMPLE, rand_vec(narrow), rand_vec(narrow), rand_vec(narrow),
                    clock_us & 48'hFFFF_FFFF_FFFF, $urandom_range(0, 1));
         end else begin
            t = clock_us + (($urandom_range(0, 19) == 0) ? {$urandom, $urandom} & 48'hFF_FFFF_FFFF
                                                       : $urandom_range(0, 2000));
            send_op(OP_TICK, rand_vec(0), rand_vec(0), rand_vec(0),
                    t & 48'hFFFF_FFFF_FFFF, $urandom_range(0, 1));
         end
      end
      drain();
   endtask

   initial begin
      gain_reg = GainReset;
      limit_reg = LimitReset;
      stale_reg = StaleReset;
      min_reg = MinReset;
      now_field = '{0, 0, 0};
      prev_field = '{0, 0, 0};
      now_time = 0;
      prev_time = 0;
      now_ok = 1'b0;
      prev_ok = 1'b0;
      law_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_extremes();

      // Random phases under several register settings.
      set_config(GainReset, LimitReset, StaleReset, MinReset);
      test_random(180, 1'b1);
      set_config(32'hFFFF_FFFF, 32'd1000, 32'hFFFF_FFFF, 32'd0);
      test_random(170, 1'b0);
      set_config($urandom, $urandom_range(0, 32767), $urandom_range(500, 5000),
                 $urandom_range(0, 2000));
      test_random(170, 1'b0);
      set_config(32'd0, 32'd32767, 32'd3000, 32'd8388607);
      test_random(170, 1'b0);
      set_config($urandom_range(1, 32'h0010_0000), $urandom_range(0, 32767),
                 32'd1000000, $urandom_range(0, 600));
      test_random(170, 1'b0);

      // Final phase runs without idling on either side.
      idling = 1'b0;
      set_config(GainReset, LimitReset, StaleReset, MinReset);
      test_random(170, 1'b0);
      repeat (20) @(posedge clock);

      $display("Sent %0d items and checked %0d results, %0d through the dipole law,",
               item_count, result_count, law_count);
      $display("under default, extreme and random register settings.");
      if (error_count == 0 && coil_queue.size() == 0)
         $display("bdot_detumble_coil_controller: match");
      else
         $display("bdot_detumble_coil_controller: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
